FILE: rtl/tts_pkg.sv
package tts_pkg;

    localparam int SLOTS  = 16;
    localparam int PRIO_W = 8;
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int GEN_W  = 16;

    localparam logic [2:0] REQ_TICK     = 3'd0;
    localparam logic [2:0] REQ_CREATE   = 3'd1;
    localparam logic [2:0] REQ_DELETE   = 3'd2;
    localparam logic [2:0] REQ_DELALL   = 3'd3;
    localparam logic [2:0] REQ_DISPATCH = 3'd4;
    localparam logic [2:0] REQ_FINISH   = 3'd5;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_BUSY   = 2'd2;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] interval;
        logic [31:0] start_delay;
        logic        use_interval_delay;
        logic [7:0]  priority_req;
        logic        periodic;
        logic [31:0] handle;
        logic        delay_wanted;
        logic [31:0] delay_ticks;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] task_handle;
        logic [31:0] now_tick;
    } out_word_t;

    typedef struct packed {
        logic              fire;
        logic [2:0]        op;
        logic [IDX_W-1:0]  sel;
        logic [31:0]       tick;
        logic [31:0]       period;
        logic [31:0]       release_tick;
        logic [PRIO_W-1:0] prio;
        logic              reload;
        logic [31:0]       handle;
        logic              delay_wanted;
        logic [31:0]       order;
    } cmd_t;

    typedef struct packed {
        logic              free_found;
        logic [IDX_W-1:0]  free_idx;
        logic [GEN_W-1:0]  free_gen;
        logic              best_found;
        logic [IDX_W-1:0]  best_idx;
        logic [PRIO_W-1:0] best_prio;
        logic [31:0]       best_order;
        logic [GEN_W-1:0]  best_gen;
    } scan_t;

    typedef struct packed {
        logic used;
        logic running;
        logic hit;
    } slot_stat_t;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_APPLY = 3'b100
    } state_t;

endpackage

FILE: rtl/timer_task_slot_scheduler.sv
// Timer task slot scheduler.
// in channel: one request word (tick, create, delete, delete all, dispatch,
// finish) per handshake, accepted when in_valid is high and in_stall low.
// out channel: exactly one result word per request: status, handle and the
// tick count after the request.
// The slots form a row of cells; a scan word runs down the row one cell per
// cycle, picking the first free slot and the best due task. A request waits
// in the scan state while the scan covers the row, then in the apply state,
// which writes its result word into the output register. The block then
// returns to idle before the next request is taken; one request is in work
// at a time.
// The result sits in an output register; the next request is taken while it
// waits. If out_stall holds, the following result waits in the apply step
// and the input stalls behind it.
// Reset (rst_n low, asynchronous) empties every slot, zeroes generations,
// the tick and order counters, and clears any running task.
module timer_task_slot_scheduler (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  tts_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_stall,
    output tts_pkg::out_word_t out_word
);

    tts_pkg::state_t           state_reg, state_next;
    logic [tts_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    tts_pkg::in_word_t         req_reg;
    logic [31:0]               tick_reg, tick_next;
    logic [31:0]               oc_reg, oc_next;
    logic                      run_valid_reg, run_valid_next;
    logic [tts_pkg::IDX_W-1:0] run_idx_reg, run_idx_next;
    logic                      out_valid_reg, out_valid_next;
    tts_pkg::out_word_t        out_reg, out_next;

    tts_pkg::cmd_t             cmd;
    tts_pkg::scan_t            chain [tts_pkg::SLOTS+1];
    tts_pkg::slot_stat_t       stat [tts_pkg::SLOTS];
    logic [tts_pkg::SLOTS-1:0] hit_vec;
    logic [tts_pkg::SLOTS-1:0] run_vec;
    tts_pkg::scan_t            last;
    logic                      go;
    logic [31:0]               oc_inc;

    assign chain[0] = '0;
    assign last     = chain[tts_pkg::SLOTS];

    for (genvar i = 0; i < tts_pkg::SLOTS; i++)
    begin : g_cell
        tts_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .idx      (tts_pkg::IDX_W'(i)),
            .cmd      (cmd),
            .scan_in  (chain[i]),
            .scan_out (chain[i+1]),
            .stat     (stat[i])
        );
        assign hit_vec[i] = stat[i].hit;
        assign run_vec[i] = stat[i].running;
    end

    assign in_stall  = (state_reg != tts_pkg::S_IDLE);
    assign go        = (state_reg == tts_pkg::S_APPLY) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    always_comb
    begin
        oc_inc = oc_reg + 32'd1;
        if (oc_inc == 32'd0)
        begin
            oc_inc = 32'd1;
        end
    end

    always_comb
    begin
        cmd.fire         = 1'b0;
        cmd.op           = req_reg.req_type;
        cmd.sel          = '0;
        cmd.tick         = tick_reg;
        cmd.period       = req_reg.interval;
        cmd.release_tick = (req_reg.req_type == tts_pkg::REQ_CREATE)
                           ? tick_reg + (req_reg.use_interval_delay ? req_reg.interval
                                                                    : req_reg.start_delay)
                           : tick_reg + req_reg.delay_ticks;
        cmd.prio         = req_reg.priority_req[tts_pkg::PRIO_W-1:0];
        cmd.reload       = req_reg.periodic;
        cmd.handle       = req_reg.handle;
        cmd.delay_wanted = req_reg.delay_wanted;
        cmd.order        = oc_inc;

        state_next     = state_reg;
        cnt_next       = cnt_reg;
        tick_next      = tick_reg;
        oc_next        = oc_reg;
        run_valid_next = run_valid_reg;
        run_idx_next   = run_idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;

        unique case (state_reg)
            tts_pkg::S_IDLE:
            begin
                cnt_next = '0;
                if (in_valid)
                begin
                    state_next = tts_pkg::S_SCAN;
                end
            end
            tts_pkg::S_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == tts_pkg::CNT_W'(tts_pkg::SLOTS - 1))
                begin
                    state_next = tts_pkg::S_APPLY;
                end
            end
            tts_pkg::S_APPLY:
            begin
                if (go)
                begin
                    state_next           = tts_pkg::S_IDLE;
                    out_valid_next       = 1'b1;
                    out_next.status      = tts_pkg::ST_REJECT;
                    out_next.task_handle = '0;
                    case (req_reg.req_type)
                        tts_pkg::REQ_TICK:
                        begin
                            tick_next       = tick_reg + 32'd1;
                            out_next.status = tts_pkg::ST_DONE;
                        end
                        tts_pkg::REQ_CREATE:
                        begin
                            if (last.free_found)
                            begin
                                cmd.fire             = 1'b1;
                                cmd.sel              = last.free_idx;
                                oc_next              = oc_inc;
                                out_next.status      = tts_pkg::ST_DONE;
                                out_next.task_handle = {last.free_gen,
                                                        16'(last.free_idx) + 16'd1};
                            end
                        end
                        tts_pkg::REQ_DELETE:
                        begin
                            cmd.fire = 1'b1;
                            if (|hit_vec)
                            begin
                                out_next.status = tts_pkg::ST_DONE;
                            end
                        end
                        tts_pkg::REQ_DELALL:
                        begin
                            cmd.fire        = 1'b1;
                            out_next.status = tts_pkg::ST_DONE;
                        end
                        tts_pkg::REQ_DISPATCH:
                        begin
                            out_next.status = tts_pkg::ST_BUSY;
                            if (!run_valid_reg && last.best_found)
                            begin
                                cmd.fire             = 1'b1;
                                cmd.sel              = last.best_idx;
                                run_valid_next       = 1'b1;
                                run_idx_next         = last.best_idx;
                                out_next.status      = tts_pkg::ST_DONE;
                                out_next.task_handle = {last.best_gen,
                                                        16'(last.best_idx) + 16'd1};
                            end
                        end
                        tts_pkg::REQ_FINISH:
                        begin
                            if (run_valid_reg)
                            begin
                                cmd.fire        = 1'b1;
                                cmd.sel         = run_idx_reg;
                                run_valid_next  = 1'b0;
                                out_next.status = tts_pkg::ST_DONE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    out_next.now_tick = tick_next;
                end
            end
            default:
            begin
                state_next = tts_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tts_pkg::S_IDLE;
            cnt_reg       <= '0;
            tick_reg      <= '0;
            oc_reg        <= '0;
            run_valid_reg <= 1'b0;
            run_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            tick_reg      <= tick_next;
            oc_reg        <= oc_next;
            run_valid_reg <= run_valid_next;
            run_idx_reg   <= run_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            req_reg <= in_word;
        end
        out_reg <= out_next;
    end

`ifndef SYNTH
    a_one_running: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(run_vec))
        else $error("more than one slot running");

    a_running_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid_reg |-> run_vec[run_idx_reg])
        else $error("running slot not marked running");

    a_idle_none_running: assert property (@(posedge clk) disable iff (!rst_n)
        !run_valid_reg |-> (run_vec == '0))
        else $error("slot running with no task tracked");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.status != 2'd3))
        else $error("bad status code");
`endif

endmodule

FILE: rtl/tts_cell.sv
module tts_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [tts_pkg::IDX_W-1:0] idx,
    input  tts_pkg::cmd_t           cmd,
    input  tts_pkg::scan_t          scan_in,
    output tts_pkg::scan_t          scan_out,
    output tts_pkg::slot_stat_t     stat
);

    logic                       used_reg, used_next;
    logic                       running_reg, running_next;
    logic                       reload_reg, reload_next;
    logic                       dp_reg, dp_next;
    logic [31:0]                period_reg, period_next;
    logic [31:0]                release_reg, release_next;
    logic [31:0]                order_reg, order_next;
    logic [tts_pkg::GEN_W-1:0]  gen_reg, gen_next;
    logic [tts_pkg::PRIO_W-1:0] prio_reg, prio_next;
    tts_pkg::scan_t             scan_reg, scan_next;

    logic [31:0]               diff;
    logic                      due;
    logic [tts_pkg::GEN_W-1:0] gen_inc;
    logic                      sel_hit;
    logic                      match;
    logic                      do_clear;

    assign diff    = cmd.tick - release_reg;
    assign due     = !diff[31];
    assign sel_hit = (cmd.sel == idx);
    assign match   = used_reg && (gen_reg == cmd.handle[31:16])
                     && (cmd.handle[15:0] == (16'(idx) + 16'd1));

    always_comb
    begin
        gen_inc = gen_reg + 1'b1;
        if (gen_inc == '0)
        begin
            gen_inc = tts_pkg::GEN_W'(1);
        end
    end

    always_comb
    begin
        scan_next = scan_in;
        if (!scan_in.free_found && !used_reg)
        begin
            scan_next.free_found = 1'b1;
            scan_next.free_idx   = idx;
            scan_next.free_gen   = gen_inc;
        end
        if (used_reg && !running_reg && due &&
            (!scan_in.best_found || prio_reg < scan_in.best_prio ||
             (prio_reg == scan_in.best_prio && order_reg < scan_in.best_order)))
        begin
            scan_next.best_found = 1'b1;
            scan_next.best_idx   = idx;
            scan_next.best_prio  = prio_reg;
            scan_next.best_order = order_reg;
            scan_next.best_gen   = gen_reg;
        end
    end

    always_comb
    begin
        used_next    = used_reg;
        running_next = running_reg;
        reload_next  = reload_reg;
        dp_next      = dp_reg;
        period_next  = period_reg;
        release_next = release_reg;
        order_next   = order_reg;
        gen_next     = gen_reg;
        prio_next    = prio_reg;
        do_clear     = 1'b0;
        if (cmd.fire)
        begin
            unique case (cmd.op)
                tts_pkg::REQ_CREATE:
                begin
                    if (sel_hit)
                    begin
                        used_next    = 1'b1;
                        running_next = 1'b0;
                        dp_next      = 1'b0;
                        gen_next     = gen_inc;
                        order_next   = cmd.order;
                        period_next  = cmd.period;
                        release_next = cmd.release_tick;
                        prio_next    = cmd.prio;
                        reload_next  = cmd.reload;
                    end
                end
                tts_pkg::REQ_DELETE, tts_pkg::REQ_DELALL:
                begin
                    if ((cmd.op == tts_pkg::REQ_DELETE) ? match : used_reg)
                    begin
                        if (running_reg)
                        begin
                            dp_next     = 1'b1;
                            reload_next = 1'b0;
                        end
                        else
                        begin
                            do_clear = 1'b1;
                        end
                    end
                end
                tts_pkg::REQ_DISPATCH:
                begin
                    if (sel_hit)
                    begin
                        running_next = 1'b1;
                    end
                end
                tts_pkg::REQ_FINISH:
                begin
                    if (sel_hit)
                    begin
                        running_next = 1'b0;
                        if (dp_reg || !reload_reg)
                        begin
                            do_clear = 1'b1;
                        end
                        else if (period_reg != 32'd0)
                        begin
                            release_next = cmd.tick + period_reg;
                        end
                        else if (cmd.delay_wanted)
                        begin
                            release_next = cmd.release_tick;
                        end
                        else
                        begin
                            do_clear = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (do_clear)
        begin
            used_next    = 1'b0;
            running_next = 1'b0;
            reload_next  = 1'b1;
            dp_next      = 1'b0;
            period_next  = '0;
            release_next = '0;
            order_next   = '0;
            prio_next    = '1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= 1'b0;
            running_reg <= 1'b0;
            reload_reg  <= 1'b1;
            dp_reg      <= 1'b0;
            period_reg  <= '0;
            release_reg <= '0;
            order_reg   <= '0;
            gen_reg     <= '0;
            prio_reg    <= '1;
            scan_reg    <= '0;
        end
        else
        begin
            used_reg    <= used_next;
            running_reg <= running_next;
            reload_reg  <= reload_next;
            dp_reg      <= dp_next;
            period_reg  <= period_next;
            release_reg <= release_next;
            order_reg   <= order_next;
            gen_reg     <= gen_next;
            prio_reg    <= prio_next;
            scan_reg    <= scan_next;
        end
    end

    assign scan_out     = scan_reg;
    assign stat.used    = used_reg;
    assign stat.running = running_reg;
    assign stat.hit     = match;

endmodule

FILE: tb/tb_timer_task_slot_scheduler.sv
module tb_timer_task_slot_scheduler;

    localparam int NSLOT    = tts_pkg::SLOTS;
    localparam int WD_LIMIT = 4000;

    localparam logic [2:0] REQ_UNUSED_A = 3'd6;
    localparam logic [2:0] REQ_UNUSED_B = 3'd7;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    tts_pkg::in_word_t  in_word;
    logic               out_valid;
    logic               out_stall;
    tts_pkg::out_word_t out_word;

    timer_task_slot_scheduler DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
    );

    // predictor copy of the slot table
    logic        t_used [NSLOT];
    logic        t_run  [NSLOT];
    logic        t_rel  [NSLOT];
    logic        t_dpend[NSLOT];
    logic [31:0] t_per  [NSLOT];
    logic [31:0] t_due  [NSLOT];
    logic [31:0] t_ord  [NSLOT];
    logic [15:0] t_gen  [NSLOT];
    logic [7:0]  t_pri  [NSLOT];
    logic [31:0] p_tick;
    logic [31:0] p_ord;
    int          p_run;
    logic [31:0] live_handles[$];

    tts_pkg::out_word_t result_q[$];
    bit        failed;
    bit        hold_off;
    int        idle_cycles;

    initial
    begin
        clk = 0;
    end
    always #2 clk = ~clk;

    function automatic void wipe_slot(int s);
        t_used[s] = 0; t_run[s] = 0; t_rel[s] = 1; t_dpend[s] = 0;
        t_per[s] = 0; t_due[s] = 0; t_ord[s] = 0; t_pri[s] = 8'hFF;
    endfunction

    function automatic void table_reset();
        for (int s = 0; s < NSLOT; s++)
        begin
            wipe_slot(s);
            t_gen[s] = 0;
        end
        p_tick = 0; p_ord = 0; p_run = NSLOT;
    endfunction

    function automatic tts_pkg::out_word_t schedule_step(tts_pkg::in_word_t w);
        tts_pkg::out_word_t r;
        int        best;
        int        s;
        logic [15:0] lo;
        r.status = tts_pkg::ST_REJECT;
        r.task_handle = 0;
        case (w.req_type)
            tts_pkg::REQ_TICK:
            begin
                p_tick++;
                r.status = tts_pkg::ST_DONE;
            end
            tts_pkg::REQ_CREATE:
                for (s = 0; s < NSLOT; s++)
                    if (!t_used[s])
                    begin
                        t_gen[s] = t_gen[s] + 16'd1;
                        if (t_gen[s] == 0) t_gen[s] = 16'd1;
                        p_ord++;
                        if (p_ord == 0) p_ord = 1;
                        t_ord[s] = p_ord;
                        t_per[s] = w.interval;
                        t_due[s] = p_tick + (w.use_interval_delay ? w.interval : w.start_delay);
                        t_pri[s] = w.priority_req;
                        t_rel[s] = w.periodic;
                        t_used[s] = 1; t_run[s] = 0; t_dpend[s] = 0;
                        r.task_handle = {t_gen[s], 16'(s + 1)};
                        r.status = tts_pkg::ST_DONE;
                        break;
                    end
            tts_pkg::REQ_DELETE:
            begin
                lo = w.handle[15:0];
                if (lo != 0 && lo <= NSLOT)
                begin
                    s = lo - 1;
                    if (t_used[s] && t_gen[s] == w.handle[31:16])
                    begin
                        if (t_run[s])
                        begin
                            t_dpend[s] = 1; t_rel[s] = 0;
                        end
                        else
                            wipe_slot(s);
                        r.status = tts_pkg::ST_DONE;
                    end
                end
            end
            tts_pkg::REQ_DELALL:
            begin
                for (s = 0; s < NSLOT; s++)
                    if (t_used[s])
                    begin
                        if (t_run[s])
                        begin
                            t_dpend[s] = 1; t_rel[s] = 0;
                        end
                        else
                            wipe_slot(s);
                    end
                r.status = tts_pkg::ST_DONE;
            end
            tts_pkg::REQ_DISPATCH:
            begin
                r.status = tts_pkg::ST_BUSY;
                if (p_run >= NSLOT)
                begin
                    best = NSLOT;
                    for (s = 0; s < NSLOT; s++)
                    begin
                        if (!t_used[s] || t_run[s]) continue;
                        if (((p_tick - t_due[s]) >> 31) != 0) continue;
                        if (best >= NSLOT || t_pri[s] < t_pri[best] ||
                            (t_pri[s] == t_pri[best] && t_ord[s] < t_ord[best]))
                            best = s;
                    end
                    if (best < NSLOT)
                    begin
                        t_run[best] = 1;
                        p_run = best;
                        r.task_handle = {t_gen[best], 16'(best + 1)};
                        r.status = tts_pkg::ST_DONE;
                    end
                end
            end
            tts_pkg::REQ_FINISH:
                if (p_run < NSLOT)
                begin
                    s = p_run;
                    p_run = NSLOT;
                    t_run[s] = 0;
                    if (t_dpend[s] || !t_rel[s])
                        wipe_slot(s);
                    else if (t_per[s] > 0)
                        t_due[s] = p_tick + t_per[s];
                    else if (w.delay_wanted)
                        t_due[s] = p_tick + w.delay_ticks;
                    else
                        wipe_slot(s);
                    r.status = tts_pkg::ST_DONE;
                end
            default: ;
        endcase
        r.now_tick = p_tick;
        return r;
    endfunction

    function automatic logic [31:0] rand32();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h7FFF_FFFF + $urandom_range(0, 2);
            default: return $urandom_range(0, 12);
        endcase
    endfunction

    function automatic tts_pkg::in_word_t rand_word(logic [2:0] op);
        tts_pkg::in_word_t w;
        w.req_type = op;
        w.interval = $urandom;
        w.start_delay = $urandom;
        w.use_interval_delay = 1'($urandom);
        w.priority_req = 8'($urandom);
        w.periodic = 1'($urandom);
        w.handle = $urandom;
        w.delay_wanted = 1'($urandom);
        w.delay_ticks = $urandom;
        if ($urandom_range(0, 3) != 0)
        begin
            w.interval = rand32();
            w.start_delay = rand32();
            w.delay_ticks = rand32();
            w.priority_req = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 3));
        end
        if (op == tts_pkg::REQ_DELETE && live_handles.size() > 0 && $urandom_range(0, 3) != 0)
            w.handle = live_handles[$urandom_range(0, live_handles.size() - 1)];
        else if (op == tts_pkg::REQ_DELETE && $urandom_range(0, 1))
            w.handle = {16'($urandom_range(0, 3)), 16'($urandom_range(0, NSLOT + 1))};
        return w;
    endfunction

    task automatic send_word(tts_pkg::in_word_t w);
        tts_pkg::out_word_t r;
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0)
        begin
            in_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1;
        in_word <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        r = schedule_step(w);
        result_q.push_back(r);
        if (w.req_type == tts_pkg::REQ_CREATE && r.status == tts_pkg::ST_DONE)
        begin
            live_handles.push_back(r.task_handle);
            if (live_handles.size() > 40) void'(live_handles.pop_front());
        end
        @(negedge clk);
    endtask

    task automatic send_op(logic [2:0] op);
        send_word(rand_word(op));
    endtask

    task automatic test_directed();
        tts_pkg::in_word_t w;
        w = '0;
        send_op(tts_pkg::REQ_FINISH);
        send_op(tts_pkg::REQ_DISPATCH);
        w.req_type = tts_pkg::REQ_DELETE; w.handle = 0; send_word(w);
        w.handle = 32'h0001_0011; send_word(w);
        w.req_type = REQ_UNUSED_A; send_word(w);
        w.req_type = REQ_UNUSED_B; send_word(w);
        w = '0; w.req_type = tts_pkg::REQ_CREATE; w.priority_req = 8'hFF; w.periodic = 1;
        w.interval = 32'hFFFF_FFFF; w.use_interval_delay = 1; send_word(w);
        w.priority_req = 0; w.interval = 0; w.use_interval_delay = 0;
        w.start_delay = 0; send_word(w);
        w.start_delay = 32'h8000_0000; send_word(w);
        send_op(tts_pkg::REQ_DISPATCH);
        send_op(tts_pkg::REQ_DISPATCH);
        w = '0; w.req_type = tts_pkg::REQ_DELETE; w.handle = 32'h0001_0002; send_word(w);
        w.req_type = tts_pkg::REQ_FINISH; w.delay_wanted = 1; w.delay_ticks = 32'hFFFF_FFFF;
        send_word(w);
        send_op(tts_pkg::REQ_DELALL);
        for (int i = 0; i < NSLOT + 1; i++)
        begin
            w = '0; w.req_type = tts_pkg::REQ_CREATE; w.priority_req = 8'(i % 2);
            w.periodic = 1; send_word(w);
        end
        send_op(tts_pkg::REQ_TICK);
        send_op(tts_pkg::REQ_DELALL);
    endtask

    task automatic test_generation_reuse();
        tts_pkg::in_word_t w;
        w = '0;
        for (int i = 0; i < 20; i++)
        begin
            w.req_type = tts_pkg::REQ_CREATE; w.handle = 0;
            send_word(w);
            w.req_type = tts_pkg::REQ_DELETE; w.handle = {t_gen[0], 16'd1};
            send_word(w);
        end
    endtask

    task automatic test_random();
        logic [2:0] op;
        for (int i = 0; i < 1200; i++)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4: op = tts_pkg::REQ_TICK;
                5, 6, 7, 8: op = tts_pkg::REQ_CREATE;
                9, 10: op = tts_pkg::REQ_DELETE;
                11: op = ($urandom_range(0, 3) == 0) ? tts_pkg::REQ_DELALL :
                         (($urandom_range(0, 1) != 0) ? REQ_UNUSED_B : REQ_UNUSED_A);
                12, 13, 14, 15: op = tts_pkg::REQ_DISPATCH;
                default: op = tts_pkg::REQ_FINISH;
            endcase
            if (i == 600) hold_off = 1;
            send_op(op);
        end
    endtask

    // receiver: random wait per word, plus one long hold-off
    initial
    begin : receiver
        int n;
        out_stall = 1;
        hold_off = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_stall <= 1;
                repeat (200) @(negedge clk);
                hold_off = 0;
            end
            n = $urandom_range(0, 3);
            if (n != 0)
            begin
                out_stall <= 1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 0;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
        begin
            if (result_q.size() == 0)
            begin
                $display("%0t unexpected result act=%h", $time, out_word);
                failed = 1;
            end
            else if (out_word !== result_q[0])
            begin
                $display("%0t mismatch exp st=%0d h=%h t=%h act st=%0d h=%h t=%h", $time,
                         result_q[0].status, result_q[0].task_handle, result_q[0].now_tick,
                         out_word.status, out_word.task_handle, out_word.now_tick);
                failed = 1;
                void'(result_q.pop_front());
            end
            else
                void'(result_q.pop_front());
        end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("tb_timer_task_slot_scheduler: errors");
            $finish;
        end
    end

    initial
    begin
        failed = 0;
        idle_cycles = 0;
        rst_n = 0;
        in_valid = 0;
        in_word = '0;
        table_reset();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        test_directed();
        test_random();
        test_generation_reuse();
        in_valid <= 0;
        while (result_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (!failed)
            $display("tb_timer_task_slot_scheduler: clean");
        else
            $display("tb_timer_task_slot_scheduler: errors");
        $finish;
    end
endmodule

FILE: timer_task_slot_scheduler.f
rtl/tts_pkg.sv
rtl/tts_cell.sv
rtl/timer_task_slot_scheduler.sv
tb/tb_timer_task_slot_scheduler.sv
